// ----- sv/rper_pkg.sv -----
// Package for the range partition edge router.
// Holds widths, operation and result kind codes, and controller/datapath structs.
// No dependencies.
`default_nettype none
package rper_pkg;

  localparam int PARTS_DEFAULT = 4;
  localparam int NODE_W        = 32;
  localparam int COUNT_W       = 32;
  localparam int ROW_W         = 32;
  localparam int KIND_W        = 2;
  localparam int PARTITION_W   = 2;
  localparam int CFG_INDEX_W   = 4;
  localparam int CFG_DATA_W    = 32;

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_EOR  = 1'b1;

  localparam logic [KIND_W-1:0] KIND_ROUTED   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NOTFOUND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BOUND    = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_edge;
    logic start_row_end;
    logic emit_record;
  } dp_cmd_t;

  typedef struct packed {
    logic touched_any;
    logic pend_last;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- sv/rper_ctrl.sv -----
// Controller for the range partition edge router.
// Sequences word acceptance and bound-record emission; depends on rper_pkg.
`default_nettype none
module rper_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire                  operation,
  output logic                 out_valid,
  input  wire                  out_stall,
  output rper_pkg::dp_cmd_t    cmd,
  input  rper_pkg::dp_status_t status
);
  import rper_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;
  logic   accept;

  assign out_free = !out_valid || !out_stall;
  // input is only taken in ST_IDLE, where in_stall is !out_free
  assign accept   = in_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && operation == OP_EOR && status.touched_any) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free && status.pend_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    in_stall       = 1'b1;
    out_valid_next = out_valid && out_stall;
    case (state)
      ST_IDLE: begin
        in_stall = !out_free;
        if (accept) begin
          if (operation == OP_EDGE) begin
            cmd.load_edge  = 1'b1;
            out_valid_next = 1'b1;
          end else begin
            cmd.start_row_end = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit_record = 1'b1;
          out_valid_next  = 1'b1;
        end
      end
      default: in_stall = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/rper_dp.sv -----
// Datapath for the range partition edge router.
// Bound registers, counters, touched flags, row counter and output word register.
// Depends on rper_pkg.
`default_nettype none
module rper_dp #(
  parameter int PARTS = rper_pkg::PARTS_DEFAULT
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_write,
  input  wire  [rper_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire  [rper_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire  [rper_pkg::NODE_W-1:0]          node,
  input  rper_pkg::dp_cmd_t                    cmd,
  output rper_pkg::dp_status_t                 status,
  output logic [rper_pkg::KIND_W-1:0]          kind,
  output logic [rper_pkg::PARTITION_W-1:0]     partition,
  output logic [rper_pkg::NODE_W-1:0]          node_out,
  output logic [rper_pkg::ROW_W-1:0]           row,
  output logic [rper_pkg::COUNT_W-1:0]         edge_count,
  output logic                                 last
);
  import rper_pkg::*;

  localparam int PART_W = (PARTS > 1) ? $clog2(PARTS) : 1;

  logic [NODE_W-1:0]  lower [PARTS];
  logic [NODE_W-1:0]  upper [PARTS];
  logic [COUNT_W-1:0] counts [PARTS];
  logic [PARTS-1:0]   touched;
  logic [PARTS-1:0]   pend;
  logic [PARTS-1:0]   pend_rest;
  logic [ROW_W-1:0]   row_index;
  logic [ROW_W-1:0]   rec_row;

  logic [PARTS-1:0]   match;
  logic               hit;
  logic [PART_W-1:0]  hit_sel;
  logic [PART_W-1:0]  rec_sel;

  always_comb begin
    hit     = 1'b0;
    hit_sel = '0;
    rec_sel = '0;
    for (int p = PARTS - 1; p >= 0; p--) begin
      match[p] = (lower[p] <= node) && (node < upper[p]);
      if (match[p]) begin
        hit     = 1'b1;
        hit_sel = PART_W'(p);
      end
      if (pend[p]) rec_sel = PART_W'(p);
    end
    for (int p = 0; p < PARTS; p++) begin
      pend_rest[p] = pend[p] && (PART_W'(p) != rec_sel);
    end
  end

  assign status.touched_any = |touched;
  assign status.pend_last   = (pend_rest == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < PARTS; p++) begin
        lower[p]  <= '0;
        upper[p]  <= '0;
        counts[p] <= '0;
      end
      touched   <= '0;
      pend      <= '0;
      row_index <= '0;
    end else begin
      for (int p = 0; p < PARTS; p++) begin
        if (cfg_write && cfg_index == CFG_INDEX_W'(2 * p)) lower[p] <= cfg_data;
        if (cfg_write && cfg_index == CFG_INDEX_W'(2 * p + 1)) upper[p] <= cfg_data;
      end
      if (cmd.load_edge && hit) begin
        if (counts[hit_sel] != '1) counts[hit_sel] <= counts[hit_sel] + 1'b1;
        touched[hit_sel] <= 1'b1;
      end
      if (cmd.start_row_end) begin
        pend    <= touched;
        touched <= '0;
        if (row_index != '1) row_index <= row_index + 1'b1;
      end
      if (cmd.emit_record) pend <= pend_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_row_end) rec_row <= row_index;
    if (cmd.load_edge) begin
      kind       <= hit ? KIND_ROUTED : KIND_NOTFOUND;
      partition  <= hit ? PARTITION_W'(hit_sel) : '0;
      node_out   <= node;
      row        <= '0;
      edge_count <= '0;
      last       <= 1'b1;
    end else if (cmd.emit_record) begin
      kind       <= KIND_BOUND;
      partition  <= PARTITION_W'(rec_sel);
      node_out   <= '0;
      row        <= rec_row;
      edge_count <= counts[rec_sel];
      last       <= status.pend_last;
    end
  end

endmodule
`default_nettype wire

// ----- sv/range_partition_edge_router.sv -----
// Range partition edge router, top level.
// Instantiates rper_ctrl and rper_dp; depends on rper_pkg.
//
// Input channel (in_valid/in_stall): one word per item, operation selects an
// edge (node is looked up) or an end of row. Output channel (out_valid/
// out_stall): one result word per transfer, last marks the final word of an item.
// An edge's result word is registered and shows in the cycle after acceptance;
// edges sustain one per cycle as long as the receiver takes words. An end of
// row snapshots the touched flags and advances the row, then gives one record
// word per cycle, while the receiver takes words, for each touched partition
// in partition order; the input is stalled while records go out. An empty row
// gives no word. When the receiver stalls, the held word stays put and the
// input stalls until the output register is freed. Reset (rst, synchronous)
// clears bounds, counts, touched flags, the row counter and the output valid.
// The user must write bounds through cfg_write/cfg_index/cfg_data only while
// idle; the block does not enforce this. Indexes at or beyond 2*PARTS are
// ignored.
`default_nettype none
module range_partition_edge_router #(
  parameter int PARTS = rper_pkg::PARTS_DEFAULT
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_write,
  input  wire  [rper_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire  [rper_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire                               operation,
  input  wire  [rper_pkg::NODE_W-1:0]       node,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [rper_pkg::KIND_W-1:0]       kind,
  output logic [rper_pkg::PARTITION_W-1:0]  partition,
  output logic [rper_pkg::NODE_W-1:0]       node_out,
  output logic [rper_pkg::ROW_W-1:0]        row,
  output logic [rper_pkg::COUNT_W-1:0]      edge_count,
  output logic                              last
);
  import rper_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  rper_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  rper_dp #(
    .PARTS (PARTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .node       (node),
    .cmd        (cmd),
    .status     (status),
    .kind       (kind),
    .partition  (partition),
    .node_out   (node_out),
    .row        (row),
    .edge_count (edge_count),
    .last       (last)
  );

endmodule
`default_nettype wire

// ----- sv/rper_chk.sv -----
// Port-level checker for the range partition edge router, with its bind.
// Depends on rper_pkg.
`default_nettype none
module rper_chk (
  input wire                               clk,
  input wire                               rst,
  input wire                               in_valid,
  input wire                               in_stall,
  input wire                               operation,
  input wire                               out_valid,
  input wire                               out_stall,
  input wire [rper_pkg::KIND_W-1:0]        kind,
  input wire [rper_pkg::PARTITION_W-1:0]   partition,
  input wire [rper_pkg::ROW_W-1:0]         row,
  input wire [rper_pkg::COUNT_W-1:0]       edge_count,
  input wire                               last
);
  import rper_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(partition)
      && $stable(row) && $stable(edge_count) && $stable(last))
    else $error("stalled output word changed");

  a_edge_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && operation == OP_EDGE |=> out_valid && last
      && (kind == KIND_ROUTED || kind == KIND_NOTFOUND))
    else $error("edge did not give one final word");

  a_edge_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_BOUND |-> last && row == '0 && edge_count == '0)
    else $error("edge word has bad fields");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output word is held");

endmodule

bind range_partition_edge_router rper_chk u_rper_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .operation  (operation),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .kind       (kind),
  .partition  (partition),
  .row        (row),
  .edge_count (edge_count),
  .last       (last)
);
`default_nettype wire
